// File: design/wtc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and control-word layout for the whitespace/tab compressor.
// No dependencies; every other file imports this package.
package wtc_pkg;

    localparam int unsigned CharW = 8;
    localparam int unsigned ColW  = 7;
    localparam int unsigned StopW = ColW + 1;
    localparam int unsigned TabW  = 5;
    localparam int unsigned LineW = 7;
    localparam int unsigned UpcW  = 4;
    localparam int unsigned KW    = 3;
    localparam int unsigned CntW  = 6;
    localparam int unsigned AddrW = 3;
    localparam int unsigned DataW = 32;
    localparam int unsigned DivSteps = 5;

    localparam logic [ColW-1:0]  MaxColumn = 7'd127;
    localparam logic [CntW-1:0]  MaxWs     = 6'd35;
    localparam logic [KW-1:0]    KTop      = KW'(DivSteps - 1);
    localparam logic [TabW-1:0]  TabMin    = 5'd4;
    localparam logic [TabW-1:0]  TabMax    = 5'd16;
    localparam logic [TabW-1:0]  TabReset  = 5'd8;
    localparam logic [LineW-1:0] LineReset = 7'd80;

    localparam logic [CharW-1:0] ChSpace = 8'h20;
    localparam logic [CharW-1:0] ChTilde = 8'h7E;
    localparam logic [CharW-1:0] ChNl    = 8'h0A;
    localparam logic [CharW-1:0] ChTab   = 8'h09;
    localparam logic [CharW-1:0] ChBell  = 8'h07;

    typedef logic [UpcW-1:0] t_upc;

    localparam t_upc UpcFetch  = 4'd0;
    localparam t_upc UpcCheck  = 4'd1;
    localparam t_upc UpcDiv    = 4'd2;
    localparam t_upc UpcStop   = 4'd3;
    localparam t_upc UpcAdv    = 4'd4;
    localparam t_upc UpcWs     = 4'd5;
    localparam t_upc UpcPrint  = 4'd6;
    localparam t_upc UpcSimple = 4'd7;
    localparam t_upc UpcCtrl   = 4'd8;
    localparam t_upc UpcTabSet = 4'd9;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIV,
        OP_STOP,
        OP_ADV,
        OP_WS,
        OP_EMIT,
        OP_SIMPLE,
        OP_TABSET
    } t_op;

    typedef enum logic [1:0] {
        W_NONE,
        W_IN,
        W_OUT
    } t_wait;

    typedef enum logic [3:0] {
        C_ALWAYS,
        C_SIMPLE,
        C_NO_DIV,
        C_K_MORE,
        C_IS_TAB,
        C_NO_PEND,
        C_WS_MORE,
        C_SILENT
    } t_cond;

    typedef enum logic {
        REG_TAB_WIDTH  = 1'b0,
        REG_LINE_WIDTH = 1'b1
    } t_reg_idx;

    typedef struct packed {
        t_op   op;
        t_wait wt;
        t_cond cond;
        t_upc  target;
    } t_cword;

    typedef struct packed {
        logic simple;
        logic no_div;
        logic k_more;
        logic is_tab;
        logic no_pend;
        logic ws_more;
        logic silent;
        logic out_free;
    } t_flags;

    typedef struct packed {
        t_op  op;
        logic fire;
        logic in_ready;
    } t_ctl;

    function automatic logic is_print(input logic [CharW-1:0] c);
        return (c > ChSpace) && (c <= ChTilde);
    endfunction

endpackage

// File: design/wtc_ucode.sv
`timescale 1ns / 1ps
// Microcode ROM: one control word per step of the compressor program.
// Depends on wtc_pkg.
module wtc_ucode (
    input  wtc_pkg::t_upc   i_upc,
    output wtc_pkg::t_cword o_cword
);
    import wtc_pkg::*;

    always_comb begin
        unique case (i_upc)
            UpcFetch:  o_cword = '{op: OP_LOAD,   wt: W_IN,   cond: C_SIMPLE,  target: UpcSimple};
            UpcCheck:  o_cword = '{op: OP_NONE,   wt: W_NONE, cond: C_NO_DIV,  target: UpcAdv};
            UpcDiv:    o_cword = '{op: OP_DIV,    wt: W_NONE, cond: C_K_MORE,  target: UpcDiv};
            UpcStop:   o_cword = '{op: OP_STOP,   wt: W_NONE, cond: C_IS_TAB,  target: UpcTabSet};
            UpcAdv:    o_cword = '{op: OP_ADV,    wt: W_NONE, cond: C_NO_PEND, target: UpcPrint};
            UpcWs:     o_cword = '{op: OP_WS,     wt: W_OUT,  cond: C_WS_MORE, target: UpcWs};
            UpcPrint:  o_cword = '{op: OP_EMIT,   wt: W_OUT,  cond: C_ALWAYS,  target: UpcFetch};
            UpcSimple: o_cword = '{op: OP_SIMPLE, wt: W_NONE, cond: C_SILENT,  target: UpcFetch};
            UpcCtrl:   o_cword = '{op: OP_EMIT,   wt: W_OUT,  cond: C_ALWAYS,  target: UpcFetch};
            UpcTabSet: o_cword = '{op: OP_TABSET, wt: W_NONE, cond: C_ALWAYS,  target: UpcFetch};
            default:   o_cword = '{op: OP_NONE,   wt: W_NONE, cond: C_ALWAYS,  target: UpcFetch};
        endcase
    end

endmodule

// File: design/wtc_sequencer.sv
`timescale 1ns / 1ps
// Step counter with conditional jumps; fetches control words from wtc_ucode.
// Depends on wtc_pkg and wtc_ucode.
module wtc_sequencer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  wtc_pkg::t_flags i_flags,
    output wtc_pkg::t_ctl   o_ctl
);
    import wtc_pkg::*;

    t_upc   r_upc;
    t_upc   n_upc;
    t_cword cw;
    logic   stall;
    logic   take;

    wtc_ucode u_ucode (
        .i_upc   (r_upc),
        .o_cword (cw)
    );

    always_comb begin
        unique case (cw.cond)
            C_ALWAYS:  take = 1'b1;
            C_SIMPLE:  take = i_flags.simple;
            C_NO_DIV:  take = i_flags.no_div;
            C_K_MORE:  take = i_flags.k_more;
            C_IS_TAB:  take = i_flags.is_tab;
            C_NO_PEND: take = i_flags.no_pend;
            C_WS_MORE: take = i_flags.ws_more;
            C_SILENT:  take = i_flags.silent;
            default:   take = 1'b0;
        endcase
    end

    // hold the step while waiting on either channel
    assign stall = ((cw.wt == W_IN) && !i_in_valid) || ((cw.wt == W_OUT) && !i_flags.out_free);

    always_comb begin
        if (stall) begin
            n_upc = r_upc;
        end else if (take) begin
            n_upc = cw.target;
        end else begin
            n_upc = r_upc + 1'b1;
        end
    end

    assign o_ctl = '{op: cw.op, fire: !stall, in_ready: (cw.wt == W_IN)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= UpcFetch;
        end else begin
            r_upc <= n_upc;
        end
    end

    a_accept_leaves_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_ctl.in_ready) |=> (r_upc != UpcFetch))
        else $error("sequencer stayed at fetch after a transaction");

endmodule

// File: design/wtc_datapath.sv
`timescale 1ns / 1ps
// Datapath: column state, remainder unit, whitespace run and output register.
// Driven by the control words of wtc_sequencer; depends on wtc_pkg.
module wtc_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  wtc_pkg::t_ctl               i_ctl,
    input  logic [wtc_pkg::CharW-1:0]   i_char_in,
    input  logic [wtc_pkg::TabW-1:0]    i_tab_width,
    input  logic [wtc_pkg::LineW-1:0]   i_line_width,
    input  logic                        i_out_ready,
    output wtc_pkg::t_flags             o_flags,
    output logic                        o_out_valid,
    output logic [wtc_pkg::CharW-1:0]   o_char_out,
    output logic [wtc_pkg::ColW-1:0]    o_column,
    output logic                        o_line_full,
    output logic                        o_last
);
    import wtc_pkg::*;

    logic [CharW-1:0] r_char,    n_char;
    logic [ColW-1:0]  r_pos,     n_pos;
    logic [ColW-1:0]  r_rem,     n_rem;
    logic [ColW-1:0]  r_lim,     n_lim;
    logic [StopW-1:0] r_stop,    n_stop;
    logic [KW-1:0]    r_k,       n_k;
    logic [CntW-1:0]  r_cnt,     n_cnt;
    logic [TabW-1:0]  r_tw,      n_tw;
    logic [ColW-1:0]  r_out_col, n_out_col;
    logic [ColW-1:0]  r_prt_col, n_prt_col;
    logic             r_o_valid, n_o_valid;
    logic [CharW-1:0] r_o_char,  n_o_char;
    logic [ColW-1:0]  r_o_col,   n_o_col;
    logic             r_o_full,  n_o_full;
    logic             r_o_last,  n_o_last;

    logic [TabW-1:0]      eff_tw;
    logic [ColW-1:0]      base;
    logic [TabW+KTop-1:0] dsub;
    logic                 rem_fits;
    logic [ColW-1:0]      col_inc;
    logic [ColW-1:0]      stop_c;
    logic                 ws_tab;
    logic [ColW-1:0]      ws_pos;
    logic [CntW-1:0]      ws_cnt;
    logic                 line_full;
    logic                 out_free;

    always_comb begin
        if (i_tab_width < TabMin) begin
            eff_tw = TabMin;
        end else if (i_tab_width > TabMax) begin
            eff_tw = TabMax;
        end else begin
            eff_tw = i_tab_width;
        end
    end

    // printing chars flush from the printed column, tabs advance from the output column
    assign base     = is_print(i_char_in) ? r_prt_col : r_out_col;
    assign dsub     = (TabW + KTop)'(r_tw) << r_k;
    assign rem_fits = (TabW + KTop)'(r_rem) >= dsub;
    assign col_inc  = (r_out_col >= MaxColumn) ? MaxColumn : r_out_col + 1'b1;
    assign stop_c   = (r_stop > StopW'(MaxColumn)) ? MaxColumn : r_stop[ColW-1:0];
    assign ws_tab   = (stop_c <= r_lim) && (stop_c > r_pos);
    assign ws_pos   = ws_tab ? stop_c : r_pos + 1'b1;
    assign ws_cnt   = r_cnt + 1'b1;
    assign line_full = r_out_col >= i_line_width;
    assign out_free = !r_o_valid || i_out_ready;

    always_comb begin
        o_flags.simple   = !is_print(i_char_in) && (i_char_in != ChTab);
        o_flags.no_div   = is_print(r_char) && (r_pos >= r_lim);
        o_flags.k_more   = (r_k != '0);
        o_flags.is_tab   = (r_char == ChTab);
        o_flags.no_pend  = (r_pos >= r_lim);
        o_flags.ws_more  = (ws_pos < r_lim) && (ws_cnt < MaxWs);
        o_flags.silent   = (r_char != ChNl) && (r_char != ChBell);
        o_flags.out_free = out_free;
    end

    always_comb begin
        n_char    = r_char;
        n_pos     = r_pos;
        n_rem     = r_rem;
        n_lim     = r_lim;
        n_stop    = r_stop;
        n_k       = r_k;
        n_cnt     = r_cnt;
        n_tw      = r_tw;
        n_out_col = r_out_col;
        n_prt_col = r_prt_col;
        n_o_valid = r_o_valid && !i_out_ready;
        n_o_char  = r_o_char;
        n_o_col   = r_o_col;
        n_o_full  = r_o_full;
        n_o_last  = r_o_last;
        if (i_ctl.fire) begin
            unique case (i_ctl.op)
                OP_LOAD: begin
                    n_char = i_char_in;
                    n_pos  = base;
                    n_rem  = base;
                    n_lim  = r_out_col;
                    n_cnt  = '0;
                    n_k    = KTop;
                    n_tw   = eff_tw;
                end
                OP_DIV: begin
                    // restoring remainder, one shifted divisor per step
                    if (rem_fits) begin
                        n_rem = r_rem - dsub[ColW-1:0];
                    end
                    n_k = r_k - 1'b1;
                end
                OP_STOP: begin
                    n_stop = StopW'(r_pos - r_rem) + StopW'(r_tw);
                end
                OP_ADV: begin
                    n_out_col = col_inc;
                    n_prt_col = col_inc;
                end
                OP_WS: begin
                    n_pos = ws_pos;
                    n_cnt = ws_cnt;
                    if (ws_tab) begin
                        n_stop = r_stop + StopW'(r_tw);
                    end
                    n_o_valid = 1'b1;
                    n_o_char  = ws_tab ? ChTab : ChSpace;
                    n_o_col   = r_out_col;
                    n_o_full  = line_full;
                    n_o_last  = 1'b0;
                end
                OP_EMIT: begin
                    n_o_valid = 1'b1;
                    n_o_char  = r_char;
                    n_o_col   = r_out_col;
                    n_o_full  = line_full;
                    n_o_last  = 1'b1;
                end
                OP_SIMPLE: begin
                    if (r_char == ChNl) begin
                        n_out_col = '0;
                        n_prt_col = '0;
                    end else if (r_char == ChSpace) begin
                        n_out_col = col_inc;
                    end
                end
                OP_TABSET: begin
                    n_out_col = stop_c;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_col <= '0;
            r_prt_col <= '0;
            r_cnt     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_out_col <= n_out_col;
            r_prt_col <= n_prt_col;
            r_cnt     <= n_cnt;
            r_o_valid <= n_o_valid;
        end
        r_char   <= n_char;
        r_pos    <= n_pos;
        r_rem    <= n_rem;
        r_lim    <= n_lim;
        r_stop   <= n_stop;
        r_k      <= n_k;
        r_tw     <= n_tw;
        r_o_char <= n_o_char;
        r_o_col  <= n_o_col;
        r_o_full <= n_o_full;
        r_o_last <= n_o_last;
    end

    assign o_out_valid = r_o_valid;
    assign o_char_out  = r_o_char;
    assign o_column    = r_o_col;
    assign o_line_full = r_o_full;
    assign o_last      = r_o_last;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.fire && (i_ctl.op == OP_WS || i_ctl.op == OP_EMIT)) |-> out_free)
        else $error("output register written while holding an untaken transaction");

    a_printed_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prt_col <= r_out_col)
        else $error("printed column ahead of output column");

    a_ws_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= MaxWs)
        else $error("whitespace run longer than allowed");

endmodule

// File: design/whitespace_tab_compressor.sv
`timescale 1ns / 1ps
// Top level of the whitespace/tab compressor: config registers and core instances.
// Depends on wtc_pkg, wtc_sequencer and wtc_datapath.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+------------------------------------------
//  input    | i_in_valid / o_in_ready     | i_char_in
//  output   | o_out_valid / i_out_ready   | o_char_out, o_column, o_line_full, o_last
//  config   | psel, penable, pwrite       | paddr, pwdata, prdata (pready tied high)
//
// Per character: space and dropped bytes are fetched and applied; newline and bell
// also emit; printing characters check, advance and emit; a tab, or a flushing
// printing character, first runs the 5-step remainder loop to find the next tab stop.
// One output register decouples the sides; each result step waits while it is full.
// Reset is synchronous: columns clear to 0, tab width 8, line width 80.
module whitespace_tab_compressor (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [wtc_pkg::CharW-1:0]   i_char_in,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [wtc_pkg::CharW-1:0]   o_char_out,
    output logic [wtc_pkg::ColW-1:0]    o_column,
    output logic                        o_line_full,
    output logic                        o_last,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [wtc_pkg::AddrW-1:0]   paddr,
    input  logic [wtc_pkg::DataW-1:0]   pwdata,
    output logic [wtc_pkg::DataW-1:0]   prdata,
    output logic                        pready
);
    import wtc_pkg::*;

    logic [TabW-1:0]  r_tab_width;
    logic [LineW-1:0] r_line_width;
    logic             cfg_wr;
    t_reg_idx         reg_idx;
    t_ctl             ctl;
    t_flags           flags;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tab_width  <= TabReset;
            r_line_width <= LineReset;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_TAB_WIDTH:  r_tab_width  <= pwdata[TabW-1:0];
                REG_LINE_WIDTH: r_line_width <= pwdata[LineW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_TAB_WIDTH:  prdata = DataW'(r_tab_width);
            REG_LINE_WIDTH: prdata = DataW'(r_line_width);
            default:        prdata = '0;
        endcase
    end

    wtc_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_flags    (flags),
        .o_ctl      (ctl)
    );

    wtc_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl),
        .i_char_in    (i_char_in),
        .i_tab_width  (r_tab_width),
        .i_line_width (r_line_width),
        .i_out_ready  (i_out_ready),
        .o_flags      (flags),
        .o_out_valid  (o_out_valid),
        .o_char_out   (o_char_out),
        .o_column     (o_column),
        .o_line_full  (o_line_full),
        .o_last       (o_last)
    );

    assign o_in_ready = ctl.in_ready;

endmodule
